>>> sv/rdc_pkg.sv
// ============================================================================
// rdc_pkg: shared constants and functions for the radix digit converter
// Field widths, divider geometry, register map and character codes.
// ============================================================================
package rdc_pkg;

    // Field widths
    localparam int VALUE_W = 31;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;
    localparam int RADIX_W = 5;

    // Divider geometry: the value sits in a 32-bit shift register and four
    // quotient bits are produced per cycle.
    localparam int DIV_W           = 32;
    localparam int STEP_BITS       = 4;
    localparam int STEPS_PER_DIGIT = DIV_W / STEP_BITS;
    localparam int STEP_CNT_W      = $clog2(STEPS_PER_DIGIT);

    // At most this many digits are ever emitted for one input.
    localparam int RESULT_CAP = 31;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_RADIX = 1'b0;

    // Radix limits
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_HEX   = 5'd16;

    // Character codes
    localparam logic [DIGIT_W-1:0] DEC_LIMIT    = 4'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0]  CHAR_NONE    = 7'h00;

    // Clamp the programmed radix into the supported range.
    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] e;
        if (r < RADIX_MIN) begin
            e = RADIX_MIN;
        end
        else if (r > RADIX_HEX) begin
            e = RADIX_HEX;
        end
        else begin
            e = r;
        end
        return e;
    endfunction

    // Character for one digit: decimal digits always, letters only in hex.
    function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d,
                                                   input logic [RADIX_W-1:0] base);
        logic [CHAR_W-1:0] c;
        if (d < DEC_LIMIT) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        else if (base == RADIX_HEX) begin
            c = CHAR_UPPER_A - CHAR_W'(DEC_LIMIT) + CHAR_W'(d);
        end
        else begin
            c = CHAR_NONE;
        end
        return c;
    endfunction

endpackage

>>> sv/rdc_ram.sv
// ============================================================================
// rdc_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered on read enable.
// ============================================================================
module rdc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Storage write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

>>> sv/radix_digit_converter.sv
// ============================================================================
// radix_digit_converter: integer to base-N digit stream
// Converts a 31-bit non-negative value to the programmed radix and emits the
// digits most significant first, one beat per digit.
// ============================================================================
// The block takes one value at a time. Each digit is found by a serial
// division that shifts the value through a 32-bit register and produces four
// quotient bits per cycle; the remainder is pushed onto a digit stack held in
// a RAM. The stack is then read back at one digit per cycle while the output
// is not stalled, after a first RAM read in the ST_READ state. A zero value
// yields a single beat with empty_res set. Radix values below 2 act as 2 and
// above 16 act as 16. Only the least significant min(MAX_DIGITS, 31) digits
// are kept. The last digit of a value still waiting at the output does not
// block the next value from being accepted.
// ============================================================================
module radix_digit_converter
    import rdc_pkg::*;
#(
    parameter int MAX_DIGITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    // Input channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [VALUE_W-1:0]  value,
    // Output channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic [DIGIT_W-1:0]  digit,
    output logic [CHAR_W-1:0]   char_code,
    output logic                empty_res,
    output logic                last
);

    localparam int LIMIT = (MAX_DIGITS < RESULT_CAP) ? MAX_DIGITS : RESULT_CAP;
    localparam int CW    = $clog2(LIMIT + 1);
    localparam int AW    = $clog2(MAX_DIGITS);
    localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(STEPS_PER_DIGIT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ZERO,
        ST_DIV,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [RADIX_W-1:0]      radix_reg, radix_next;
    logic [RADIX_W-1:0]      base_reg, base_next;
    logic [DIV_W-1:0]        sh_reg, sh_next;
    logic [DIGIT_W-1:0]      rem_reg, rem_next;
    logic [STEP_CNT_W-1:0]   step_reg, step_next;
    logic                    qnz_reg, qnz_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           ptr_reg, ptr_next;
    logic                    out_valid_reg, out_valid_next;
    logic [DIGIT_W-1:0]      digit_reg, digit_next;
    logic [CHAR_W-1:0]       char_reg, char_next;
    logic                    empty_reg, empty_next;
    logic                    last_reg, last_next;

    logic [STEP_BITS-1:0]    q_bits;
    logic [DIGIT_W-1:0]      div_rem;
    logic                    slot_free;
    logic                    cfg_write;
    logic                    push;
    logic                    ram_we;
    logic                    ram_re;
    logic [AW-1:0]           ram_waddr;
    logic [AW-1:0]           ram_raddr;
    logic [DIGIT_W-1:0]      ram_rdata;

    // Configuration register access.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_RADIX);
    assign prdata    = (paddr[PADDR_W-1:2] == REG_RADIX) ? PDATA_W'(radix_reg) : '0;

    // Handshake outputs.
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign digit     = digit_reg;
    assign char_code = char_reg;
    assign empty_res = empty_reg;
    assign last      = last_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // Four restoring division steps on the top bits of the shift register.
    always_comb
    begin
        logic [DIGIT_W:0]   t;
        logic [DIGIT_W-1:0] r;
        r      = rem_reg;
        q_bits = '0;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            t = {r, sh_reg[DIV_W-1-i]};
            if (t >= (DIGIT_W+1)'(base_reg))
            begin
                q_bits[STEP_BITS-1-i] = 1'b1;
                r = DIGIT_W'(t - (DIGIT_W+1)'(base_reg));
            end
            else
            begin
                r = t[DIGIT_W-1:0];
            end
        end
        div_rem = r;
    end

    // Digit stack writes and reads.
    assign push      = (state_reg == ST_DIV) && (step_reg == STEP_LAST)
                       && (count_reg < CW'(LIMIT));
    assign ram_we    = push;
    assign ram_waddr = AW'(count_reg);
    assign ram_re    = (state_reg == ST_READ)
                       || ((state_reg == ST_EMIT) && slot_free && (ptr_reg != '0));
    assign ram_raddr = (state_reg == ST_READ) ? AW'(ptr_reg) : AW'(ptr_reg - CW'(1));

    rdc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (div_rem),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        radix_next     = radix_reg;
        base_next      = base_reg;
        sh_next        = sh_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        qnz_next       = qnz_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        digit_next     = digit_reg;
        char_next      = char_reg;
        empty_next     = empty_reg;
        last_next      = last_reg;

        if (cfg_write)
        begin
            radix_next = pwdata[RADIX_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    base_next = eff_radix(radix_reg);
                    sh_next   = DIV_W'(value);
                    rem_next  = '0;
                    step_next = '0;
                    qnz_next  = 1'b0;
                    count_next = '0;
                    state_next = (value == '0) ? ST_ZERO : ST_DIV;
                end
            end
            ST_ZERO:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    digit_next     = '0;
                    char_next      = CHAR_NONE;
                    empty_next     = 1'b1;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                sh_next   = {sh_reg[DIV_W-STEP_BITS-1:0], q_bits};
                rem_next  = div_rem;
                step_next = step_reg + STEP_CNT_W'(1);
                qnz_next  = qnz_reg || (q_bits != '0);
                if (step_reg == STEP_LAST)
                begin
                    rem_next = '0;
                    qnz_next = 1'b0;
                    if (push)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    // Quotient reached zero: the stack holds every kept digit.
                    if (!qnz_reg && (q_bits == '0))
                    begin
                        ptr_next   = push ? count_reg : count_reg - CW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    digit_next     = ram_rdata;
                    char_next      = char_of(ram_rdata, base_reg);
                    empty_next     = 1'b0;
                    last_next      = (ptr_reg == '0);
                    if (ptr_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_RESET;
            base_reg      <= RADIX_RESET;
            sh_reg        <= '0;
            rem_reg       <= '0;
            step_reg      <= '0;
            qnz_reg       <= 1'b0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
            digit_reg     <= '0;
            char_reg      <= '0;
            empty_reg     <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            radix_reg     <= radix_next;
            base_reg      <= base_next;
            sh_reg        <= sh_next;
            rem_reg       <= rem_next;
            step_reg      <= step_next;
            qnz_reg       <= qnz_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
            digit_reg     <= digit_next;
            char_reg      <= char_next;
            empty_reg     <= empty_next;
            last_reg      <= last_next;
        end
    end

endmodule

>>> sv/rdc_checker.sv
// ============================================================================
// rdc_checker: port-level checks for the radix digit converter
// Watches the channels of the top level and flags illegal result beats.
// ============================================================================
module rdc_checker
    import rdc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [DIGIT_W-1:0] digit,
    input logic [CHAR_W-1:0]  char_code,
    input logic               empty_res,
    input logic               last
);

    // A stalled result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digit) && $stable(char_code)
                                    && $stable(empty_res) && $stable(last))
        else $error("result beat changed while stalled");

    // The empty result of a zero value is a lone, final, zero beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_res |-> last && (digit == '0) && (char_code == CHAR_NONE))
        else $error("malformed empty result");

    // Decimal digits always carry their character code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !empty_res && (digit < DEC_LIMIT)
        |-> char_code == CHAR_ZERO + CHAR_W'(digit))
        else $error("wrong character code for decimal digit");

    // One value at a time: no input beat right after an accepted one.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);
